### sv/ikhm_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the integer-keyed hash map.
// No dependencies; front, back and top refer to it by scoped names, the bench imports it.

package ikhm_pkg;

	localparam int DEF_CAPACITY = 256;
	localparam int QUEUE_DEPTH  = 2;

	localparam int KEY_W    = 32;
	localparam int VAL_W    = 32;
	localparam int STATUS_W = 3;

	// splitmix64 finalizer constants
	localparam logic [63:0] MIX_ADD  = 64'h9e3779b97f4a7c15;
	localparam logic [63:0] MIX_MUL1 = 64'hbf58476d1ce4e5b9;
	localparam logic [63:0] MIX_MUL2 = 64'h94d049bb133111eb;
	localparam int MIX_SH0 = 30;
	localparam int MIX_SH1 = 27;
	localparam int MIX_SH2 = 31;

	// load limit is LOAD_NUM / LOAD_DEN of capacity
	localparam int LOAD_NUM = 7;
	localparam int LOAD_DEN = 10;

	localparam logic KIND_PUT = 1'b0;
	localparam logic KIND_GET = 1'b1;

	typedef enum logic [STATUS_W-1:0] {
		ST_INSERTED  = 3'd0,
		ST_UPDATED   = 3'd1,
		ST_FOUND     = 3'd2,
		ST_NOT_FOUND = 3'd3,
		ST_ZERO_KEY  = 3'd4,
		ST_FULL      = 3'd5
	} status_t;

	typedef struct packed {
		logic             zero_key;
		logic             kind;
		logic [KEY_W-1:0] key;
		logic [VAL_W-1:0] value;
	} req_t;

	typedef enum logic [1:0] {
		F_IDLE,
		F_MUL,
		F_MOD,
		F_PUSH
	} fstate_t;

	typedef enum logic [1:0] {
		B_CLEAR,
		B_IDLE,
		B_PROBE
	} bstate_t;

endpackage

### sv/integer_keyed_hash_map.sv
`timescale 1ns / 1ps
// Top level of the integer-keyed hash map: front hasher, request queue and
// probing back end. Depends on ikhm_pkg, ikhm_front, ikhm_fifo, ikhm_back.
//
// Usage
//   Request channel: present kind/key/value and raise push; the beat is taken
//   at a clock edge with push high and full low. kind 0 is a put (insert or
//   update), kind 1 a get. Key zero is answered with the zero-key status.
//   Result channel: while empty is low, status/read_value hold the oldest
//   answer; it is taken at an edge with pop high. Exactly one result beat per
//   request beat, in request order.
// Flow
//   The front runs the splitmix64 finalizer as six partial products through
//   one shared 32x32 multiplier, plus a byte-serial remainder when CAPACITY
//   is not a power of two; full stays high until it has handed its request
//   to the queue, so it takes a new request only then. A zero key skips the
//   hash. The back starts each request from idle, then probes slots in turn
//   through the single slot RAM read port; the result is registered when a
//   slot decides it. A zero key is answered at the start, without a probe.
// Reset
//   After arst_n the back sweeps the slot RAM clearing every key, one slot a
//   cycle, and full stays high until the sweep is done.
// Backpressure
//   One result is held while pop is low; the front keeps working and the
//   two-entry queue absorbs requests until it fills, then the front holds
//   its finished request and full stays high.

module integer_keyed_hash_map #(
	parameter int CAPACITY = ikhm_pkg::DEF_CAPACITY
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic                          kind,
	input  logic [ikhm_pkg::KEY_W-1:0]    key,
	input  logic [ikhm_pkg::VAL_W-1:0]    value,
	output logic                          empty,
	input  logic                          pop,
	output logic [ikhm_pkg::STATUS_W-1:0] status,
	output logic [ikhm_pkg::VAL_W-1:0]    read_value
);

	localparam int SLOT_W = $clog2(CAPACITY);
	localparam int Q_W    = $bits(ikhm_pkg::req_t) + SLOT_W;

	// front -> queue
	logic              f_push, q_full;
	ikhm_pkg::req_t    f_req;
	logic [SLOT_W-1:0] f_slot;

	// queue -> back
	logic              q_empty, q_pop;
	logic [Q_W-1:0]    q_head;
	ikhm_pkg::req_t    b_req;
	logic [SLOT_W-1:0] b_slot;

	// back keeps requests out while the slot RAM is being cleared
	logic              clearing;

	assign {b_req, b_slot} = q_head;

	ikhm_front #(
		.CAPACITY (CAPACITY)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.kind     (kind),
		.key      (key),
		.value    (value),
		.clearing (clearing),
		.q_full   (q_full),
		.q_push   (f_push),
		.q_req    (f_req),
		.q_slot   (f_slot)
	);

	ikhm_fifo #(
		.WIDTH (Q_W),
		.DEPTH (ikhm_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (f_push),
		.wdata  ({f_req, f_slot}),
		.full   (q_full),
		.rd     (q_pop),
		.rdata  (q_head),
		.empty  (q_empty)
	);

	ikhm_back #(
		.CAPACITY (CAPACITY)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_empty    (q_empty),
		.q_req      (b_req),
		.q_slot     (b_slot),
		.q_pop      (q_pop),
		.clearing   (clearing),
		.empty      (empty),
		.pop        (pop),
		.status     (status),
		.read_value (read_value)
	);

endmodule

### sv/ikhm_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.

module ikhm_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 256,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### sv/ikhm_fifo.sv
`timescale 1ns / 1ps
// Small register FIFO that decouples the hashing front from the probing back.
// No dependencies.

module ikhm_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2,
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int CW = $clog2(DEPTH + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             rd,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	logic [WIDTH-1:0] ent_q [DEPTH];
	logic [PW-1:0]    wp_q, rp_q;
	logic [CW-1:0]    cnt_q;
	logic             do_wr, do_rd;

	assign full  = (cnt_q == CW'(DEPTH));
	assign empty = (cnt_q == '0);
	assign do_wr = wr && !full;
	assign do_rd = rd && !empty;
	assign rdata = ent_q[rp_q];

	function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
		return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr) begin
				wp_q <= bump(wp_q);
			end
			if (do_rd) begin
				rp_q <= bump(rp_q);
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			ent_q[wp_q] <= wdata;
		end
	end

endmodule

### sv/ikhm_front.sv
`timescale 1ns / 1ps
// Front end: takes request beats, flags zero keys and computes the home slot
// with a shared 32x32 multiplier. Depends on ikhm_pkg.

module ikhm_front #(
	parameter int CAPACITY = ikhm_pkg::DEF_CAPACITY,
	localparam int SLOT_W = $clog2(CAPACITY)
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     push,
	output logic                     full,
	input  logic                     kind,
	input  logic [ikhm_pkg::KEY_W-1:0] key,
	input  logic [ikhm_pkg::VAL_W-1:0] value,
	input  logic                     clearing,
	input  logic                     q_full,
	output logic                     q_push,
	output ikhm_pkg::req_t           q_req,
	output logic [SLOT_W-1:0]        q_slot
);

	localparam bit IS_POW2 = ((CAPACITY & (CAPACITY - 1)) == 0);
	localparam logic [SLOT_W:0] CAP_EXT = (SLOT_W + 1)'(CAPACITY);

	ikhm_pkg::fstate_t state_q, state_d;
	ikhm_pkg::req_t    req_q;
	logic [63:0]       mula_q, prod_q, acc_q, z_q;
	logic [1:0]        step_q;
	logic              pass_q;
	logic [2:0]        byte_q;
	logic [SLOT_W-1:0] r_q;

	logic        accept;
	logic [63:0] z0, mix0, mul_c, fin;
	logic [31:0] mul_x, mul_y;
	logic [63:0] mul_p;
	logic [SLOT_W-1:0] r_nx;

	assign accept = push && !full;
	assign z0     = {32'h0, key} + ikhm_pkg::MIX_ADD;
	assign mix0   = z0 ^ (z0 >> ikhm_pkg::MIX_SH0);
	assign mul_c  = pass_q ? ikhm_pkg::MIX_MUL2 : ikhm_pkg::MIX_MUL1;
	// partial products: lo*lo, lo*hi, hi*lo (the hi*hi term falls off the top)
	assign mul_x  = (step_q == 2'd2) ? mula_q[63:32] : mula_q[31:0];
	assign mul_y  = (step_q == 2'd1) ? mul_c[63:32] : mul_c[31:0];
	assign mul_p  = 64'(mul_x) * 64'(mul_y);
	assign fin    = acc_q + {prod_q[31:0], 32'h0};

	// eight restoring remainder steps, one hash byte per cycle
	always_comb begin
		logic [SLOT_W:0] t;
		t = {1'b0, r_q};
		for (int i = 7; i >= 0; i--) begin
			t = {t[SLOT_W-1:0], z_q[56 + i]};
			if (t >= CAP_EXT) begin
				t = t - CAP_EXT;
			end
		end
		r_nx = t[SLOT_W-1:0];
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ikhm_pkg::F_IDLE: begin
				if (accept) begin
					state_d = (key == '0) ? ikhm_pkg::F_PUSH : ikhm_pkg::F_MUL;
				end
			end
			ikhm_pkg::F_MUL: begin
				if (step_q == 2'd3 && pass_q) begin
					state_d = IS_POW2 ? ikhm_pkg::F_PUSH : ikhm_pkg::F_MOD;
				end
			end
			ikhm_pkg::F_MOD: begin
				if (byte_q == 3'd7) begin
					state_d = ikhm_pkg::F_PUSH;
				end
			end
			ikhm_pkg::F_PUSH: begin
				if (!q_full) begin
					state_d = ikhm_pkg::F_IDLE;
				end
			end
			default: state_d = ikhm_pkg::F_IDLE;
		endcase
	end

	always_comb begin
		full   = (state_q != ikhm_pkg::F_IDLE) || clearing;
		q_push = (state_q == ikhm_pkg::F_PUSH) && !q_full;
		q_req  = req_q;
		q_slot = IS_POW2 ? z_q[SLOT_W-1:0] : r_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ikhm_pkg::F_IDLE;
			step_q  <= '0;
			pass_q  <= 1'b0;
			byte_q  <= '0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				step_q <= '0;
				pass_q <= 1'b0;
				byte_q <= '0;
			end else if (state_q == ikhm_pkg::F_MUL) begin
				step_q <= step_q + 1'b1;
				if (step_q == 2'd3) begin
					pass_q <= 1'b1;
				end
			end else if (state_q == ikhm_pkg::F_MOD) begin
				byte_q <= byte_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q  <= '{zero_key: (key == '0), kind: kind, key: key, value: value};
			mula_q <= mix0;
			z_q    <= '0;
		end
		if (state_q == ikhm_pkg::F_MUL) begin
			case (step_q)
				2'd0: begin
					prod_q <= mul_p;
				end
				2'd1: begin
					acc_q  <= prod_q;
					prod_q <= mul_p;
				end
				2'd2: begin
					acc_q  <= fin;
					prod_q <= mul_p;
				end
				default: begin
					if (!pass_q) begin
						mula_q <= fin ^ (fin >> ikhm_pkg::MIX_SH1);
					end else begin
						z_q <= fin ^ (fin >> ikhm_pkg::MIX_SH2);
						r_q <= '0;
					end
				end
			endcase
		end
		if (state_q == ikhm_pkg::F_MOD) begin
			r_q <= r_nx;
			z_q <= z_q << 8;
		end
	end

endmodule

### sv/ikhm_back.sv
`timescale 1ns / 1ps
// Back end: clears the slot store after reset, then probes it linearly for
// each queued nonzero key and holds one result. Depends on ikhm_pkg, ikhm_ram.

module ikhm_back #(
	parameter int CAPACITY = ikhm_pkg::DEF_CAPACITY,
	localparam int SLOT_W = $clog2(CAPACITY)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          q_empty,
	input  ikhm_pkg::req_t                q_req,
	input  logic [SLOT_W-1:0]             q_slot,
	output logic                          q_pop,
	output logic                          clearing,
	output logic                          empty,
	input  logic                          pop,
	output logic [ikhm_pkg::STATUS_W-1:0] status,
	output logic [ikhm_pkg::VAL_W-1:0]    read_value
);

	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int LIMIT = (ikhm_pkg::LOAD_NUM * CAPACITY + ikhm_pkg::LOAD_DEN - 1)
		/ ikhm_pkg::LOAD_DEN - 1;
	localparam logic [SLOT_W-1:0] LAST = SLOT_W'(CAPACITY - 1);
	localparam int WORD_W = ikhm_pkg::KEY_W + ikhm_pkg::VAL_W;

	ikhm_pkg::bstate_t state_q, state_d;
	ikhm_pkg::req_t    req_q;
	logic [SLOT_W-1:0] clr_q, slot_q, probe_q;
	logic [CNT_W-1:0]  count_q;
	logic              out_valid_q;
	ikhm_pkg::status_t out_status_q;
	logic [ikhm_pkg::VAL_W-1:0] out_value_q;

	logic                 we;
	logic [SLOT_W-1:0]    waddr, raddr, slot_nx;
	logic [WORD_W-1:0]    wdata, rdata;
	logic [ikhm_pkg::KEY_W-1:0] rkey;
	logic [ikhm_pkg::VAL_W-1:0] rval;
	logic                 out_free, start, hit, vacant, last, at_limit, is_put;
	logic                 done, wr, ins, set_out;
	ikhm_pkg::status_t    res_status;
	logic [ikhm_pkg::VAL_W-1:0] res_value;

	ikhm_ram #(
		.WIDTH (WORD_W),
		.DEPTH (CAPACITY)
	) u_slots (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign rkey     = rdata[WORD_W-1:ikhm_pkg::VAL_W];
	assign rval     = rdata[ikhm_pkg::VAL_W-1:0];
	assign out_free = !out_valid_q || pop;
	assign start    = (state_q == ikhm_pkg::B_IDLE) && !q_empty && out_free;
	assign hit      = (rkey == req_q.key);
	assign vacant   = (rkey == '0);
	assign last     = (probe_q == LAST);
	assign at_limit = (count_q >= CNT_W'(LIMIT));
	assign is_put   = (req_q.kind == ikhm_pkg::KIND_PUT);
	assign slot_nx  = (slot_q == LAST) ? '0 : slot_q + 1'b1;

	always_comb begin
		res_value = '0;
		wr        = 1'b0;
		ins       = 1'b0;
		if (hit) begin
			res_status = is_put ? ikhm_pkg::ST_UPDATED : ikhm_pkg::ST_FOUND;
			res_value  = is_put ? '0 : rval;
			wr         = is_put;
		end else if (vacant) begin
			if (!is_put) begin
				res_status = ikhm_pkg::ST_NOT_FOUND;
			end else if (at_limit) begin
				res_status = ikhm_pkg::ST_FULL;
			end else begin
				res_status = ikhm_pkg::ST_INSERTED;
				wr         = 1'b1;
				ins        = 1'b1;
			end
		end else begin
			res_status = is_put ? ikhm_pkg::ST_FULL : ikhm_pkg::ST_NOT_FOUND;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ikhm_pkg::B_CLEAR: begin
				if (clr_q == LAST) begin
					state_d = ikhm_pkg::B_IDLE;
				end
			end
			ikhm_pkg::B_IDLE: begin
				if (start && !q_req.zero_key) begin
					state_d = ikhm_pkg::B_PROBE;
				end
			end
			ikhm_pkg::B_PROBE: begin
				if (hit || vacant || last) begin
					state_d = ikhm_pkg::B_IDLE;
				end
			end
			default: state_d = ikhm_pkg::B_IDLE;
		endcase
	end

	always_comb begin
		clearing = (state_q == ikhm_pkg::B_CLEAR);
		done     = (state_q == ikhm_pkg::B_PROBE) && (hit || vacant || last);
		q_pop    = start;
		set_out  = done || (start && q_req.zero_key);
		we       = clearing || (done && wr);
		waddr    = clearing ? clr_q : slot_q;
		wdata    = clearing ? '0 : {req_q.key, req_q.value};
		raddr    = (state_q == ikhm_pkg::B_IDLE) ? q_slot : slot_nx;
		empty      = !out_valid_q;
		status     = out_status_q;
		read_value = out_value_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ikhm_pkg::B_CLEAR;
			clr_q       <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (clearing) begin
				clr_q <= clr_q + 1'b1;
			end
			if (done && ins) begin
				count_q <= count_q + 1'b1;
			end
			if (set_out) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			req_q   <= q_req;
			slot_q  <= q_slot;
			probe_q <= '0;
		end else if (state_q == ikhm_pkg::B_PROBE) begin
			slot_q  <= slot_nx;
			probe_q <= probe_q + 1'b1;
		end
		if (start && q_req.zero_key) begin
			out_status_q <= ikhm_pkg::ST_ZERO_KEY;
			out_value_q  <= '0;
		end else if (done) begin
			out_status_q <= res_status;
			out_value_q  <= res_value;
		end
	end

endmodule

### test/integer_keyed_hash_map_test.sv
`timescale 1ns / 1ps
// Self-checking bench for integer_keyed_hash_map: directed cases, then random
// put/get traffic over four idle/stall phases. Depends on ikhm_pkg and the integer_keyed_hash_map RTL.

module integer_keyed_hash_map_test;

	import ikhm_pkg::*;

	localparam int MAP_CAP        = DEF_CAPACITY;
	localparam int RANDOM_BEATS   = 300;   // per idling phase, four phases
	localparam int LONG_HOLD      = 400;   // receiver hold-off, in cycles
	localparam int SETTLE_CYCLES  = 40;    // quiet time after the last result
	// Worst quiet stretch: the reset sweep or the long hold-off, plus a probe
	// across the longest cluster. Several times over that.
	localparam int WATCHDOG_LIMIT = 4000;

	typedef struct {
		logic             kind;
		logic [KEY_W-1:0] key;
		logic [VAL_W-1:0] value;
	} map_req_t;

	typedef struct {
		status_t          st;
		logic [VAL_W-1:0] rv;
	} map_answer_t;

	logic                clk;
	logic                arst_n     = 1'b0;
	logic                push       = 1'b0;
	logic                kind       = KIND_PUT;
	logic [KEY_W-1:0]    key        = '0;
	logic [VAL_W-1:0]    value      = '0;
	logic                pop        = 1'b0;
	logic                full;
	logic                empty;
	logic [STATUS_W-1:0] status;
	logic [VAL_W-1:0]    read_value;

	integer_keyed_hash_map DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.kind       (kind),
		.key        (key),
		.value      (value),
		.empty      (empty),
		.pop        (pop),
		.status     (status),
		.read_value (read_value)
	);

	// Shadow of the slot store, updated as each request beat is accepted.
	logic [KEY_W-1:0] shadow_keys   [MAP_CAP];
	logic [VAL_W-1:0] shadow_values [MAP_CAP];
	int unsigned      shadow_count;

	map_req_t         pending_reqs[$];      // requests waiting to be offered
	map_answer_t      expected_answers[$];  // answers owed by the block
	logic [KEY_W-1:0] known_keys[$];        // every nonzero key ever put

	int  send_gap_pct   = 0;
	int  pop_stall_pct  = 0;
	bit  long_hold_req  = 1'b0;
	int  hold_left      = 0;
	bit  req_taken      = 1'b0;
	int  mismatch_count = 0;
	int  req_count      = 0;
	int  result_count   = 0;
	int  quiet_cycles   = 0;
	int  status_seen[8];

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// ---------------------------------------------------------------------
	// Prediction
	// ---------------------------------------------------------------------

	// splitmix64 finalizer; the home slot is its low bits for a 2^n capacity
	function automatic int unsigned home_slot(input logic [KEY_W-1:0] k);
		logic [63:0] z;
		z = {32'h0, k} + MIX_ADD;
		z = (z ^ (z >> MIX_SH0)) * MIX_MUL1;
		z = (z ^ (z >> MIX_SH1)) * MIX_MUL2;
		z = z ^ (z >> MIX_SH2);
		return 32'(z % 64'(MAP_CAP));
	endfunction

	// Linear probe from the home slot; applies the put to the shadow store.
	task automatic lookup_or_store(input map_req_t rq, output map_answer_t ans);
		int unsigned slot;
		bit          at_limit;
		ans.st = ST_NOT_FOUND;
		ans.rv = '0;
		if (rq.key == '0) begin
			ans.st = ST_ZERO_KEY;
		end else begin
			slot     = home_slot(rq.key);
			at_limit = (shadow_count + 1) * LOAD_DEN >= MAP_CAP * LOAD_NUM;
			// probing every slot without a hit or a hole
			if (rq.kind == KIND_PUT) begin
				ans.st = ST_FULL;
			end
			for (int probes = 0; probes < MAP_CAP; probes++) begin
				if (shadow_keys[slot] == rq.key) begin
					if (rq.kind == KIND_PUT) begin
						shadow_values[slot] = rq.value;
						ans.st = ST_UPDATED;
					end else begin
						ans.rv = shadow_values[slot];
						ans.st = ST_FOUND;
					end
					break;
				end
				if (shadow_keys[slot] == '0) begin
					if (rq.kind == KIND_GET) begin
						ans.st = ST_NOT_FOUND;
					end else if (at_limit) begin
						ans.st = ST_FULL;
					end else begin
						shadow_keys[slot]   = rq.key;
						shadow_values[slot] = rq.value;
						shadow_count++;
						ans.st = ST_INSERTED;
					end
					break;
				end
				slot = (slot + 1 == MAP_CAP) ? 0 : slot + 1;
			end
		end
	endtask

	// ---------------------------------------------------------------------
	// Stimulus helpers
	// ---------------------------------------------------------------------

	function automatic logic [KEY_W-1:0] random_key();
		logic [KEY_W-1:0] k;
		k = $urandom;
		if (k == '0) begin
			k = 32'h1;
		end
		return k;
	endfunction

	// keys that hash near the top of the table exercise the wrap to slot 0
	function automatic logic [KEY_W-1:0] key_homed_from(input int unsigned lowest);
		logic [KEY_W-1:0] k;
		do begin
			k = random_key();
		end while (home_slot(k) < lowest);
		return k;
	endfunction

	task automatic queue_request(input logic k, input logic [KEY_W-1:0] ky,
			input logic [VAL_W-1:0] v);
		map_req_t rq;
		rq.kind  = k;
		rq.key   = ky;
		rq.value = v;
		pending_reqs.push_back(rq);
		if (k == KIND_PUT && ky != '0) begin
			known_keys.push_back(ky);
		end
	endtask

	// Half are puts and gets of keys already used, and new keys are put, so the table
	// fills to its load limit and probe chains grow; some zero keys and absent lookups.
	task automatic queue_random_request();
		int unsigned pick;
		logic [KEY_W-1:0] old_key;
		pick = $urandom_range(0, 99);
		old_key = (known_keys.size() != 0)
			? known_keys[$urandom_range(0, known_keys.size() - 1)] : random_key();
		if (pick < 5) begin
			queue_request(1'($urandom), '0, $urandom);
		end else if (pick < 28) begin
			queue_request(KIND_PUT, random_key(), $urandom);
		end else if (pick < 35) begin
			queue_request(KIND_PUT, key_homed_from(MAP_CAP - 4), $urandom);
		end else if (pick < 55) begin
			queue_request(KIND_PUT, old_key, $urandom);
		end else if (pick < 85) begin
			queue_request(KIND_GET, old_key, $urandom);
		end else begin
			queue_request(KIND_GET, random_key(), $urandom);
		end
	endtask

	task automatic wait_drained();
		while (pending_reqs.size() != 0 || expected_answers.size() != 0) begin
			@(posedge clk);
		end
	endtask

	// ---------------------------------------------------------------------
	// Driver: request beats change on the falling edge. A beat is held until
	// the monitor sees it taken; the next one, if any and not held back by a send gap, is offered in the same step.
	// ---------------------------------------------------------------------
	always @(negedge clk) begin
		if (arst_n) begin
			if (!push || req_taken) begin
				if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_gap_pct) begin
					push  <= 1'b1;
					kind  <= pending_reqs[0].kind;
					key   <= pending_reqs[0].key;
					value <= pending_reqs[0].value;
				end else begin
					push <= 1'b0;
				end
			end
			req_taken = 1'b0;
		end
	end

	// Receiver: random stalls, plus one long hold-off counted here so the
	// block backs up and raises full while the driver keeps offering.
	always @(negedge clk) begin
		if (arst_n) begin
			if (long_hold_req) begin
				hold_left     = LONG_HOLD;
				long_hold_req = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				pop <= 1'b0;
			end else begin
				pop <= ($urandom_range(0, 99) >= pop_stall_pct);
			end
		end
	end

	// ---------------------------------------------------------------------
	// Monitor: sample both handshakes on the rising edge, predict on each
	// request beat, check each result beat against the oldest answer.
	// ---------------------------------------------------------------------
	always @(posedge clk) begin : monitor
		map_req_t    seen_req;
		map_answer_t want;
		bit          moved;
		if (arst_n) begin
			moved = 1'b0;
			if (push && !full) begin
				seen_req.kind  = kind;
				seen_req.key   = key;
				seen_req.value = value;
				lookup_or_store(seen_req, want);
				expected_answers.push_back(want);
				void'(pending_reqs.pop_front());
				req_taken = 1'b1;
				req_count++;
				moved = 1'b1;
			end
			if (pop && !empty) begin
				moved = 1'b1;
				result_count++;
				status_seen[status]++;
				if (expected_answers.size() == 0) begin
					mismatch_count++;
					$display("%0t: result beat with nothing expected: status %0d read_value %h",
						$time, status, read_value);
				end else begin
					want = expected_answers.pop_front();
					if (status !== want.st) begin
						mismatch_count++;
						$display("%0t: status expected %0d (%s) actual %0d",
							$time, want.st, want.st.name(), status);
					end
					if (read_value !== want.rv) begin
						mismatch_count++;
						$display("%0t: read_value expected %h actual %h",
							$time, want.rv, read_value);
					end
				end
			end
			quiet_cycles = moved ? 0 : quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: no beat for %0d cycles, %0d answers outstanding",
					$time, quiet_cycles, expected_answers.size());
				$display("FAILED: results differ");
				$finish;
			end
		end
	end

	// ---------------------------------------------------------------------
	// Sequence
	// ---------------------------------------------------------------------
	initial begin : sequencer
		logic [KEY_W-1:0] wrap_a;
		logic [KEY_W-1:0] wrap_b;
		logic [KEY_W-1:0] wrap_absent;
		for (int s = 0; s < MAP_CAP; s++) begin
			shadow_keys[s]   = '0;
			shadow_values[s] = '0;
		end
		shadow_count = 0;
		foreach (status_seen[i]) begin
			status_seen[i] = 0;
		end

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: zero key, field extremes, update, probe wrap past the
		// last slot, lookup that stops at an empty slot.
		wrap_a = key_homed_from(MAP_CAP - 1);
		do begin
			wrap_b = key_homed_from(MAP_CAP - 1);
		end while (wrap_b == wrap_a);
		do begin
			wrap_absent = key_homed_from(MAP_CAP - 1);
		end while (wrap_absent == wrap_a || wrap_absent == wrap_b);

		queue_request(KIND_GET, 32'h0000_0001, 32'h0);
		queue_request(KIND_PUT, 32'h0, 32'hFFFF_FFFF);
		queue_request(KIND_GET, 32'h0, 32'h0);
		queue_request(KIND_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		queue_request(KIND_GET, 32'hFFFF_FFFF, 32'h0);
		queue_request(KIND_PUT, 32'hFFFF_FFFF, 32'h0);
		queue_request(KIND_GET, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		queue_request(KIND_PUT, 32'h0000_0001, 32'h8000_0000);
		queue_request(KIND_GET, 32'h0000_0001, 32'hDEAD_BEEF);   // value ignored
		queue_request(KIND_PUT, wrap_a, 32'h1234_5678);
		queue_request(KIND_PUT, wrap_b, 32'h0000_0001);           // lands in slot 0
		queue_request(KIND_GET, wrap_b, 32'h0);
		queue_request(KIND_GET, wrap_a, 32'h0);
		queue_request(KIND_PUT, wrap_b, 32'h7FFF_FFFF);
		queue_request(KIND_GET, wrap_b, 32'h0);
		queue_request(KIND_GET, wrap_absent, 32'h0);               // runs past the wrap
		queue_request(KIND_GET, 32'h8000_0000, 32'h0);
		wait_drained();

		// Random phases; each one drains before the next, so the driver also
		// pauses with nothing in flight. Later phases run against a table held
		// at its load limit, where new inserts come back full.
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					send_gap_pct  = 0;
					pop_stall_pct = 0;
					long_hold_req = 1'b1;
				end
				1: begin
					send_gap_pct  = 50;
					pop_stall_pct = 0;
				end
				2: begin
					send_gap_pct  = 0;
					pop_stall_pct = 50;
				end
				default: begin
					send_gap_pct  = 6;
					pop_stall_pct = 6;
				end
			endcase
			repeat (RANDOM_BEATS) queue_random_request();
			wait_drained();
		end

		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Ran %0d requests, %0d results, over four idle/stall phases and a long hold-off.",
			req_count, result_count);
		$display("Statuses: ins %0d upd %0d found %0d miss %0d zero %0d full %0d; %0d keys stored.",
			status_seen[ST_INSERTED], status_seen[ST_UPDATED], status_seen[ST_FOUND],
			status_seen[ST_NOT_FOUND], status_seen[ST_ZERO_KEY], status_seen[ST_FULL],
			shadow_count);
		if (mismatch_count == 0 && expected_answers.size() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule

### filelist.f
sv/ikhm_pkg.sv
sv/ikhm_ram.sv
sv/ikhm_fifo.sv
sv/ikhm_front.sv
sv/ikhm_back.sv
sv/integer_keyed_hash_map.sv
test/integer_keyed_hash_map_test.sv
